// ===== sv/fp8m_pkg.sv =====
// Package for the FP8 E5M2 widening multiplier: request and result types
// and constants. No dependencies.
package fp8m_pkg;

  localparam logic [31:0] CanonNan = 32'h7FC0_0000;
  localparam logic [4:0]  ExpMax   = 5'h1F;
  localparam logic [7:0]  ExpBias  = 8'h61;

  typedef struct packed {
    logic [7:0] operand_a;
    logic [7:0] operand_b;
  } req_t;

  typedef struct packed {
    logic [31:0] product_bits;
    logic        invalid_flag;
  } res_t;

endpackage

// ===== sv/fp8_e5m2_widening_multiply.sv =====
// Top level of the FP8 E5M2 widening multiplier: input register, product
// datapath (fp8m_core) and result register. Depends on fp8m_pkg, fp8m_core.
//
// Usage: a request carries two FP8 E5M2 factors on req_i, qualified by
// req_valid_i; the block stalls the sender with req_stall_o. Each request
// yields one result on res_o (exact binary32 product and invalid flag),
// qualified by res_valid_o and held while res_stall_i is high.
// The request is captured in an input register, the product is formed by
// short combinational logic and captured in a result register when both
// stages advance. Throughput is one request per cycle: both stages advance
// together whenever the result register is empty or being taken.
// When the receiver stalls, the result register holds and, once the input
// register is also full, req_stall_o rises; nothing is dropped.
// Reset clears both valid bits; payload registers are not reset.
module fp8_e5m2_widening_multiply (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_stall_o,
  input  fp8m_pkg::req_t req_i,
  output logic           res_valid_o,
  input  logic           res_stall_i,
  output fp8m_pkg::res_t res_o
);
  import fp8m_pkg::*;

  logic in_vld_q;
  req_t in_q;
  logic out_vld_q;
  res_t out_q;
  res_t core_res;
  logic advance;

  fp8m_core u_core (.req_i(in_q), .res_o(core_res));

  // The pipeline moves when the result slot is free or is taken this cycle.
  assign advance     = !out_vld_q || !res_stall_i;
  assign req_stall_o = in_vld_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (advance) begin
        out_vld_q <= in_vld_q;
        in_vld_q  <= req_valid_i;
      end else if (!in_vld_q) begin
        in_vld_q <= req_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance || !in_vld_q) in_q <= req_i;
    if (advance) out_q <= core_res;
  end

  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_stall_i |=> res_valid_o && $stable(res_o))
    else $error("result changed while stalled");
  a_nostall_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> !req_stall_o)
    else $error("stall raised with empty input register");
  a_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !req_stall_o |=> res_valid_o)
    else $error("request lost between stages");

endmodule

// ===== sv/fp8m_core.sv =====
// Combinational FP8 E5M2 product datapath producing binary32 bits.
// Depends on fp8m_pkg.
module fp8m_core (
  input  fp8m_pkg::req_t req_i,
  output fp8m_pkg::res_t res_o
);
  import fp8m_pkg::*;

  logic       sa, sb, sz;
  logic [4:0] ea, eb;
  logic [1:0] fa, fb;
  logic       nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic [1:0] xa, xb;     // exponent offset: 0 for normal
  logic [2:0] ga, gb;
  logic [5:0] p;
  logic [7:0] xz;
  logic [22:0] man;

  always_comb begin
    sa = req_i.operand_a[7];
    sb = req_i.operand_b[7];
    ea = req_i.operand_a[6:2];
    eb = req_i.operand_b[6:2];
    fa = req_i.operand_a[1:0];
    fb = req_i.operand_b[1:0];
    sz = sa ^ sb;
    nan_a  = (ea == ExpMax) && (fa != 2'b00);
    nan_b  = (eb == ExpMax) && (fb != 2'b00);
    inf_a  = (ea == ExpMax) && (fa == 2'b00);
    inf_b  = (eb == ExpMax) && (fb == 2'b00);
    zero_a = (ea == 5'd0) && (fa == 2'b00);
    zero_b = (eb == 5'd0) && (fb == 2'b00);
    // Subnormals are normalized; the biased exponent contribution is
    // e for normals, 0 or -1 for subnormals (handled as a subtraction).
    if (ea == 5'd0) begin
      xa = fa[1] ? 2'd0 : 2'd1;
      ga = fa[1] ? {fa, 1'b0} : {fa[0], 2'b00};
    end else begin
      xa = 2'd0;
      ga = {1'b1, fa};
    end
    if (eb == 5'd0) begin
      xb = fb[1] ? 2'd0 : 2'd1;
      gb = fb[1] ? {fb, 1'b0} : {fb[0], 2'b00};
    end else begin
      xb = 2'd0;
      gb = {1'b1, fb};
    end
    p  = {3'b000, ga} * {3'b000, gb};
    xz = {3'b000, ea} + {3'b000, eb} + ExpBias + {7'd0, p[5]}
         - {6'd0, xa} - {6'd0, xb};
    man = p[5] ? {p[4:0], 18'd0} : {p[3:0], 19'd0};

    res_o.invalid_flag = 1'b0;
    if (nan_a || nan_b) begin
      res_o.product_bits = CanonNan;
      res_o.invalid_flag = (nan_a && fa == 2'b01) || (nan_b && fb == 2'b01);
    end else if (inf_a || inf_b) begin
      if (zero_a || zero_b) begin
        res_o.product_bits = CanonNan;
        res_o.invalid_flag = 1'b1;
      end else begin
        res_o.product_bits = {sz, 8'hFF, 23'd0};
      end
    end else if (zero_a || zero_b) begin
      res_o.product_bits = {sz, 31'd0};
    end else begin
      res_o.product_bits = {sz, xz, man};
    end
  end

endmodule

// ===== tb/sv/tb_fp8_e5m2_widening_multiply.sv =====
// Testbench for the FP8 E5M2 widening multiplier: drives random and directed
// operand pairs, predicts the binary32 product and checks every result.
// Depends on fp8m_pkg and fp8_e5m2_widening_multiply.
`timescale 1ns / 1ps

// Scoreboard: holds the predicted products in arrival order and compares
// each result from the block with the oldest one.
class fp8m_product_board;
  fp8m_pkg::res_t pending_q[$];
  int unsigned    err_count;

  // Predicts the exact product of two E5M2 factors as binary32 bits.
  function fp8m_pkg::res_t predict(fp8m_pkg::req_t req);
    fp8m_pkg::res_t r;
    logic       sa, sb, sz;
    logic [4:0] ea, eb;
    logic [1:0] fa, fb;
    logic       nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    int         xa, xb, xz;
    int unsigned ga, gb, p, man;
    sa = req.operand_a[7];
    sb = req.operand_b[7];
    ea = req.operand_a[6:2];
    eb = req.operand_b[6:2];
    fa = req.operand_a[1:0];
    fb = req.operand_b[1:0];
    sz = sa ^ sb;
    nan_a  = (ea == fp8m_pkg::ExpMax) && (fa != 0);
    nan_b  = (eb == fp8m_pkg::ExpMax) && (fb != 0);
    inf_a  = (ea == fp8m_pkg::ExpMax) && (fa == 0);
    inf_b  = (eb == fp8m_pkg::ExpMax) && (fb == 0);
    zero_a = (ea == 0) && (fa == 0);
    zero_b = (eb == 0) && (fb == 0);
    r.invalid_flag = 1'b0;
    if (nan_a || nan_b) begin
      // A fraction of 01 marks a signaling NaN.
      r.product_bits = fp8m_pkg::CanonNan;
      r.invalid_flag = (nan_a && fa == 2'b01) || (nan_b && fb == 2'b01);
    end else if (inf_a || inf_b) begin
      if (zero_a || zero_b) begin
        r.product_bits = fp8m_pkg::CanonNan;
        r.invalid_flag = 1'b1;
      end else begin
        r.product_bits = {sz, 8'hFF, 23'd0};
      end
    end else if (zero_a || zero_b) begin
      r.product_bits = {sz, 31'd0};
    end else begin
      // Subnormals are normalized so each significand lies in 4..7.
      if (ea == 0) begin
        xa = fa[1] ? 0 : -1;
        ga = fa[1] ? fa << 1 : fa << 2;
      end else begin
        xa = ea;
        ga = {1'b1, fa};
      end
      if (eb == 0) begin
        xb = fb[1] ? 0 : -1;
        gb = fb[1] ? fb << 1 : fb << 2;
      end else begin
        xb = eb;
        gb = {1'b1, fb};
      end
      p  = ga * gb;
      xz = xa + xb + 97;
      if (p >= 32) begin
        xz  = xz + 1;
        man = (p & 31) << 18;
      end else begin
        man = (p & 15) << 19;
      end
      r.product_bits = {sz, xz[7:0], man[22:0]};
    end
    return r;
  endfunction

  function void note_request(fp8m_pkg::req_t req);
    pending_q.push_back(predict(req));
  endfunction

  function void check_result(fp8m_pkg::res_t got);
    fp8m_pkg::res_t want;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result product=%h invalid=%b", $time,
               got.product_bits, got.invalid_flag);
      err_count++;
      return;
    end
    want = pending_q.pop_front();
    if (got.product_bits !== want.product_bits) begin
      $display("%0t: product_bits expected %h actual %h", $time,
               want.product_bits, got.product_bits);
      err_count++;
    end
    if (got.invalid_flag !== want.invalid_flag) begin
      $display("%0t: invalid_flag expected %b actual %b", $time,
               want.invalid_flag, got.invalid_flag);
      err_count++;
    end
  endfunction
endclass

module tb_fp8_e5m2_widening_multiply;
  localparam int unsigned NumRandom = 750;
  localparam int unsigned CycleLimit = 200000;

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           req_valid_i = 1'b0;
  logic           req_stall_o;
  fp8m_pkg::req_t req_i = '0;
  logic           res_valid_o;
  logic           res_stall_i = 1'b1;
  fp8m_pkg::res_t res_o;

  fp8m_product_board board = new();
  int unsigned cycle_count = 0;

  fp8_e5m2_widening_multiply dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_stall_o (req_stall_o),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall_i),
    .res_o       (res_o)
  );

  always #5 clk_i = ~clk_i;

  // The run ends here if the block hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Sampling happens on the edge itself, before the nonblocking updates of
  // the drivers land, so every check sees the values that the block saw.
  always @(posedge clk_i) begin
    if (rst_ni && req_valid_i && !req_stall_o) begin
      board.note_request(req_i);
    end
    if (rst_ni && res_valid_o && !res_stall_i) begin
      board.check_result(res_o);
    end
  end

  // Sends one request after a random gap of idle cycles. Long runs with no
  // gap come from a separate mode so back-to-back traffic is covered too.
  // Valid is lowered only when a gap follows, so it is never assigned twice
  // in one time step.
  task automatic send_request(input logic [7:0] a, input logic [7:0] b,
                              input bit no_gap);
    int unsigned gap;
    gap = no_gap ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_valid_i <= 1'b1;
    req_i       <= '{operand_a: a, operand_b: b};
    @(posedge clk_i);
    while (req_stall_o) @(posedge clk_i);
  endtask

  // The receiver stalls for a random number of cycles, then takes the next
  // result; in some stretches it never stalls at all.
  initial begin : receiver
    int unsigned wait_cycles;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 7) == 0) begin
        res_stall_i <= 1'b0;
        repeat ($urandom_range(5, 40)) @(posedge clk_i);
      end else begin
        wait_cycles = $urandom_range(0, 18);
        if (wait_cycles > 0) begin
          res_stall_i <= 1'b1;
          repeat (wait_cycles) @(posedge clk_i);
        end
        res_stall_i <= 1'b0;
        @(posedge clk_i);
        while (!res_valid_o) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    logic [7:0] special_q[$];
    bit          burst;
    int unsigned burst_left;
    special_q = '{8'h00, 8'h80, 8'h01, 8'h82, 8'h03, 8'h04, 8'h7B, 8'hFB,
                  8'h7C, 8'hFC, 8'h7D, 8'hFE, 8'h7F, 8'h3C};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: zero, subnormals, largest normal, infinities, both NaN
    // kinds, and the infinity times zero case.
    for (int i = 0; i < 21; i++) begin
      send_request(special_q[i % special_q.size()],
                   special_q[(i * 5 + 3) % special_q.size()], 1'b0);
    end
    send_request(8'h7C, 8'h00, 1'b0);
    send_request(8'h7D, 8'h7E, 1'b0);
    send_request(8'hFF, 8'hFD, 1'b0);

    // Random part: mostly fully random bytes, sometimes a special operand,
    // with bursts of back-to-back requests.
    burst_left = 0;
    for (int i = 0; i < NumRandom; i++) begin
      logic [7:0] a, b;
      a = 8'($urandom_range(0, 255));
      b = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 5) == 0) a = special_q[$urandom_range(0, 13)];
      if ($urandom_range(0, 5) == 0) b = special_q[$urandom_range(0, 13)];
      if (burst_left == 0 && $urandom_range(0, 9) == 0) begin
        burst_left = $urandom_range(4, 20);
      end
      burst = (burst_left > 1) && (i != NumRandom - 1);
      if (burst_left > 0) burst_left--;
      send_request(a, b, burst);
    end
    req_valid_i <= 1'b0;

    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (board.err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
